// ----- hdl/terrain_tile_transition_mask_select_defines.svh -----
// assertion macros for the terrain tile transition mask select block
`ifndef TERRAIN_TILE_TRANSITION_MASK_SELECT_DEFINES_SVH
`define TERRAIN_TILE_TRANSITION_MASK_SELECT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define TTMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define TTMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ttms_pkg.sv -----
// shared types, codes and tables of the terrain tile transition mask select block
`default_nettype none

package ttms_pkg;

    localparam int CELL_W = 3;
    localparam int ID_W   = 16;
    localparam int VAR_W  = 4;
    localparam int ROT_W  = 2;
    localparam int SIZE_W = 4;
    localparam int ZONE_W = 4;
    localparam int ROW_W  = 2;

    // operation codes carried in s_tuser
    localparam logic OP_CLEAR    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // draw kinds carried in m_tuser
    localparam logic [1:0] DRAW_NONE   = 2'd0;
    localparam logic [1:0] DRAW_FULL   = 2'd1;
    localparam logic [1:0] DRAW_MASKED = 2'd2;

    // configuration register indexes
    localparam logic REG_REGION_WIDTH  = 1'b0;
    localparam logic REG_REGION_HEIGHT = 1'b1;
    localparam logic [SIZE_W-1:0] REGION_SIZE_RESET = 4'd8;

    // rotation codes
    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    // zone codes that a covered cell does not draw
    localparam logic [ZONE_W-1:0] ZONE_NONE = 4'd0;
    localparam logic [ZONE_W-1:0] ZONE_ALL  = 4'd15;

    // texel sizes as shift amounts: 64 per tile, 64 per mask, 32 per sub-cell
    localparam int TILE_SHIFT = 6;
    localparam int MASK_SHIFT = 6;
    localparam int SUB_SHIFT  = 5;

    // coverage generation tags kept in the coverage memory
    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 4'd0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'd15;

    // one input item as packed in s_tdata (last member in the lowest bits)
    typedef struct packed {
        logic [ROT_W-1:0]  block_rotation;
        logic [VAR_W-1:0]  texture_variant;
        logic [VAR_W-1:0]  mask_variant;
        logic [ID_W-1:0]   corner_bottom_left;
        logic [ID_W-1:0]   corner_bottom_right;
        logic [ID_W-1:0]   corner_top_right;
        logic [ID_W-1:0]   corner_top_left;
        logic [ID_W-1:0]   tile_id;
        logic [CELL_W-1:0] cell_y;
        logic [CELL_W-1:0] cell_x;
    } cell_item_t;

    // one result as packed in m_tdata (last member in the lowest bits)
    typedef struct packed {
        logic [1:0] mask_rotation;
        logic [7:0] mask_y;
        logic [9:0] mask_x;
        logic [1:0] tex_rotation;
        logic [5:0] tex_y;
        logic [9:0] tex_x;
        logic [7:0] screen_y;
        logic [7:0] screen_x;
    } result_t;

    // what the evaluation asks of the coverage logic
    typedef struct packed {
        logic is_clear;
        logic set_covered;
    } eval_ctrl_t;

    // mask row per zone, in units of the mask size
    function automatic logic [ROW_W-1:0] mask_row(input logic [ZONE_W-1:0] zone);
        logic [ROW_W-1:0] row;
        case (zone)
            4'd0:    row = 2'd0;
            4'd1:    row = 2'd3;
            4'd2:    row = 2'd3;
            4'd3:    row = 2'd2;
            4'd4:    row = 2'd3;
            4'd5:    row = 2'd0;
            4'd6:    row = 2'd2;
            4'd7:    row = 2'd1;
            4'd8:    row = 2'd3;
            4'd9:    row = 2'd2;
            4'd10:   row = 2'd0;
            4'd11:   row = 2'd1;
            4'd12:   row = 2'd2;
            4'd13:   row = 2'd1;
            4'd14:   row = 2'd1;
            default: row = 2'd0;
        endcase
        return row;
    endfunction

    // mask rotation per zone
    function automatic logic [ROT_W-1:0] mask_rot(input logic [ZONE_W-1:0] zone);
        logic [ROT_W-1:0] rot;
        case (zone)
            4'd0:    rot = 2'd0;
            4'd1:    rot = 2'd3;
            4'd2:    rot = 2'd2;
            4'd3:    rot = 2'd2;
            4'd4:    rot = 2'd1;
            4'd5:    rot = 2'd2;
            4'd6:    rot = 2'd1;
            4'd7:    rot = 2'd2;
            4'd8:    rot = 2'd0;
            4'd9:    rot = 2'd3;
            4'd10:   rot = 2'd1;
            4'd11:   rot = 2'd3;
            4'd12:   rot = 2'd0;
            4'd13:   rot = 2'd0;
            4'd14:   rot = 2'd1;
            default: rot = 2'd0;
        endcase
        return rot;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/terrain_tile_transition_mask_select.sv -----
// top level: coverage read-modify-write pipeline around the tag memory
//
//  channel   handshake          payload
//  s_        s_tvalid/s_tready  s_tdata cell item, s_tuser op
//  m_        m_tvalid/m_tready  m_tdata result offsets, m_tuser draw kind
//  cfg_wr_   cfg_wr_en          cfg_wr_index, cfg_wr_data (no read-back)
//
// one item per cycle while m_ takes results and no sweep is pending; an accepted item is
// registered in the read stage, then in the output register, where m_tvalid rises
// the coverage memory is read at acceptance, then tested and written back from the read stage
// after reset and after every 15th clear the memory is swept, all MAX_SIDE*MAX_SIDE entries,
// with s_tready low
// a stalled m_ side holds one result in the output register and one item in the read stage
`default_nettype none

`include "terrain_tile_transition_mask_select_defines.svh"

module terrain_tile_transition_mask_select #(
    parameter int MAX_SIDE       = 8,
    parameter int TEXEL_PER_CELL = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cell_x, cell_y, tile_id, corner_top_left, corner_top_right,
    // corner_bottom_right, corner_bottom_left, mask_variant, texture_variant,
    // block_rotation
    input  wire logic [95:0] s_tdata,
    // op
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // screen_x, screen_y, tex_x, tex_y, tex_rotation, mask_x, mask_y,
    // mask_rotation, 2 zero bits
    output logic      [55:0] m_tdata,
    // draw_kind
    output logic      [1:0]  m_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_index,
    input  wire logic [3:0]  cfg_wr_data
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] SWEEP_END = ADDR_W'(DEPTH - 1);

    // configuration
    logic [ttms_pkg::SIZE_W-1:0] width_reg;
    logic [ttms_pkg::SIZE_W-1:0] height_reg;
    logic [ttms_pkg::SIZE_W-1:0] w_eff;
    logic [ttms_pkg::SIZE_W-1:0] h_eff;

    // read stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_op_reg;
    ttms_pkg::cell_item_t  s1_item_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;

    // coverage generation, sweep and forwarding
    logic [ttms_pkg::EPOCH_W-1:0] epoch_reg;
    logic [ttms_pkg::EPOCH_W-1:0] epoch_next;
    logic                         sweep_reg;
    logic                         sweep_next;
    logic [ADDR_W-1:0]            sweep_cnt_reg;
    logic [ADDR_W-1:0]            sweep_cnt_next;
    logic                         last_wr_valid_reg;
    logic                         last_wr_valid_next;
    logic [ADDR_W-1:0]            last_wr_addr_reg;

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           out_kind_reg;
    ttms_pkg::result_t    out_res_reg;

    // datapath
    ttms_pkg::cell_item_t         in_item;
    logic [ADDR_W-1:0]            in_addr;
    logic                         accept;
    logic                         s1_adv;
    logic                         s1_wrap;
    logic [ttms_pkg::EPOCH_W-1:0] rd_tag;
    logic                         covered;
    logic [1:0]                   ev_kind;
    ttms_pkg::result_t            ev_res;
    ttms_pkg::eval_ctrl_t         ev_ctrl;
    logic                         mem_wr_en;
    logic [ADDR_W-1:0]            mem_wr_addr;
    logic [ttms_pkg::EPOCH_W-1:0] mem_wr_data;

    assign in_item = ttms_pkg::cell_item_t'(s_tdata);
    assign in_addr = ADDR_W'(int'(in_item.cell_y) * MAX_SIDE + int'(in_item.cell_x));

    // a clear that wraps the generation must leave an empty pipeline for the sweep
    assign s1_wrap  = s1_valid_reg && (s1_op_reg == ttms_pkg::OP_CLEAR)
                      && (epoch_reg == ttms_pkg::EPOCH_LAST);
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !sweep_reg && !s1_wrap && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = ttms_pkg::SIZE_W'(1);
        end else if (int'(width_reg) > MAX_SIDE) begin
            w_eff = ttms_pkg::SIZE_W'(MAX_SIDE);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = ttms_pkg::SIZE_W'(1);
        end else if (int'(height_reg) > MAX_SIDE) begin
            h_eff = ttms_pkg::SIZE_W'(MAX_SIDE);
        end else begin
            h_eff = height_reg;
        end
    end

    ttms_cov_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ttms_pkg::EPOCH_W)
    ) u_cov_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_tag)
    );

    // the previous item's write can land at the same edge as this item's read
    assign covered = (rd_tag == epoch_reg)
                     || (last_wr_valid_reg && (last_wr_addr_reg == s1_addr_reg));

    ttms_cell_eval #(
        .TEXEL_PER_CELL (TEXEL_PER_CELL)
    ) u_cell_eval (
        .op        (s1_op_reg),
        .item      (s1_item_reg),
        .covered   (covered),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .draw_kind (ev_kind),
        .res       (ev_res),
        .ctrl      (ev_ctrl)
    );

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = s1_addr_reg;
        mem_wr_data = epoch_reg;
        if (sweep_reg) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_cnt_reg;
            mem_wr_data = ttms_pkg::EPOCH_NONE;
        end else if (s1_adv && ev_ctrl.set_covered) begin
            mem_wr_en = 1'b1;
        end
    end

    always_comb begin
        s1_valid_next      = s1_valid_reg;
        out_valid_next     = out_valid_reg;
        epoch_next         = epoch_reg;
        sweep_next         = sweep_reg;
        sweep_cnt_next     = sweep_cnt_reg;
        last_wr_valid_next = last_wr_valid_reg;

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (sweep_reg) begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
            if (sweep_cnt_reg == SWEEP_END) begin
                sweep_next = 1'b0;
            end
        end

        if (s1_adv && ev_ctrl.is_clear) begin
            last_wr_valid_next = 1'b0;
            if (epoch_reg == ttms_pkg::EPOCH_LAST) begin
                epoch_next     = ttms_pkg::EPOCH_FIRST;
                sweep_next     = 1'b1;
                sweep_cnt_next = '0;
            end else begin
                epoch_next = epoch_reg + 1'b1;
            end
        end else if (s1_adv && ev_ctrl.set_covered) begin
            last_wr_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg         <= ttms_pkg::REGION_SIZE_RESET;
            height_reg        <= ttms_pkg::REGION_SIZE_RESET;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            epoch_reg         <= ttms_pkg::EPOCH_FIRST;
            sweep_reg         <= 1'b1;
            sweep_cnt_reg     <= '0;
            last_wr_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    ttms_pkg::REG_REGION_WIDTH:  width_reg  <= cfg_wr_data;
                    ttms_pkg::REG_REGION_HEIGHT: height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
            epoch_reg         <= epoch_next;
            sweep_reg         <= sweep_next;
            sweep_cnt_reg     <= sweep_cnt_next;
            last_wr_valid_reg <= last_wr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg   <= s_tuser;
            s1_item_reg <= in_item;
            s1_addr_reg <= in_addr;
        end
        if (s1_adv) begin
            out_kind_reg <= ev_kind;
            out_res_reg  <= ev_res;
        end
        if (s1_adv && ev_ctrl.set_covered) begin
            last_wr_addr_reg <= s1_addr_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_res_reg};

    `TTMS_ASSERT_NOW(a_sweep_pipe_empty, sweep_reg, !s1_valid_reg, "item in read stage during sweep")
    `TTMS_ASSERT_NEXT(a_clear_drops_fwd, s1_adv && ev_ctrl.is_clear, !last_wr_valid_reg, "forward survived clear")
    `TTMS_ASSERT_NOW(a_epoch_live, 1'b1, epoch_reg != ttms_pkg::EPOCH_NONE, "epoch holds the sweep tag")
    `TTMS_ASSERT_NOW(a_none_zero, m_tvalid && (m_tuser == ttms_pkg::DRAW_NONE), m_tdata == '0, "empty result carries data")

endmodule

`default_nettype wire

// ----- hdl/ttms_cov_ram.sv -----
// coverage tag memory: one write port, one registered read port
`default_nettype none

module ttms_cov_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-first: a write at the same edge is not seen here
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ttms_cell_eval.sv -----
// corner matching, coverage decision, mask table lookup and offsets for one cell
`default_nettype none

module ttms_cell_eval #(
    parameter int TEXEL_PER_CELL = 32
) (
    input  wire logic                                op,
    input  wire ttms_pkg::cell_item_t                item,
    input  wire logic                                covered,
    input  wire logic [ttms_pkg::SIZE_W-1:0]         w_eff,
    input  wire logic [ttms_pkg::SIZE_W-1:0]         h_eff,
    output logic      [1:0]                          draw_kind,
    output ttms_pkg::result_t                        res,
    output ttms_pkg::eval_ctrl_t                     ctrl
);

    localparam logic [7:0] TEXEL_STEP = 8'(TEXEL_PER_CELL);

    logic [ttms_pkg::ZONE_W-1:0] zone;
    logic                        in_region;
    logic                        subx;
    logic                        suby;
    logic                        wx_par;
    logic                        hy_par;

    assign zone = {item.corner_bottom_left  == item.tile_id,
                   item.corner_bottom_right == item.tile_id,
                   item.corner_top_right    == item.tile_id,
                   item.corner_top_left     == item.tile_id};

    assign in_region = ({1'b0, item.cell_x} < w_eff) && ({1'b0, item.cell_y} < h_eff);

    // parity of (size - pos - 1) for mirrored sub-cell picks
    assign wx_par = ~(w_eff[0] ^ item.cell_x[0]);
    assign hy_par = ~(h_eff[0] ^ item.cell_y[0]);

    always_comb begin
        case (item.block_rotation)
            ttms_pkg::ROT_90: begin
                subx = hy_par;
                suby = item.cell_x[0];
            end
            ttms_pkg::ROT_180: begin
                subx = wx_par;
                suby = hy_par;
            end
            ttms_pkg::ROT_270: begin
                subx = item.cell_y[0];
                suby = wx_par;
            end
            default: begin
                subx = item.cell_x[0];
                suby = item.cell_y[0];
            end
        endcase
    end

    always_comb begin
        draw_kind        = ttms_pkg::DRAW_NONE;
        res              = '0;
        ctrl.is_clear    = (op == ttms_pkg::OP_CLEAR);
        ctrl.set_covered = 1'b0;

        if (op == ttms_pkg::OP_CLASSIFY && in_region) begin
            if (!covered) begin
                if (zone != ttms_pkg::ZONE_NONE) begin
                    draw_kind        = ttms_pkg::DRAW_FULL;
                    ctrl.set_covered = 1'b1;
                end
            end else if (zone != ttms_pkg::ZONE_NONE && zone != ttms_pkg::ZONE_ALL) begin
                draw_kind         = ttms_pkg::DRAW_MASKED;
                res.mask_x        = {item.mask_variant, 6'd0};
                res.mask_y        = {ttms_pkg::mask_row(zone), 6'd0};
                res.mask_rotation = ttms_pkg::mask_rot(zone);
            end
        end

        if (draw_kind != ttms_pkg::DRAW_NONE) begin
            res.screen_x     = {5'd0, item.cell_x} * TEXEL_STEP;
            res.screen_y     = {5'd0, item.cell_y} * TEXEL_STEP;
            res.tex_x        = {item.texture_variant, subx, 5'd0};
            res.tex_y        = {suby, 5'd0};
            res.tex_rotation = item.block_rotation;
        end
    end

endmodule

`default_nettype wire
